// ===== rtl/b24fb_pkg.sv =====
// ----------------------------------------------------------------------------
// b24fb_pkg
// Shared types, status codes and header layout for the 24-bit BMP stream
// to frame buffer decoder.
// ----------------------------------------------------------------------------
package b24fb_pkg;

    // widths
    localparam int DEFAULT_ADDRESS_BITS = 20;
    localparam int ADDR_OUT_BITS        = 20;
    localparam int CAP_BITS             = 21;
    localparam int USEFUL_BITS          = 24;
    localparam int ROW_BITS             = 22;
    localparam int HDR_POS_BITS         = 6;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 21'd1048576;

    // header layout
    localparam logic [31:0] HDR_BYTES      = 32'd54;
    localparam logic [31:0] HDR_CHECK_POS  = 32'd53;
    localparam logic [31:0] MIN_INFO_LEN   = 32'd40;
    localparam logic [7:0]  SIG_B          = 8'h42;
    localparam logic [7:0]  SIG_M          = 8'h4D;
    localparam logic [15:0] DEPTH_24       = 16'd24;

    localparam logic [HDR_POS_BITS-1:0] POS_SIG0      = 6'd0;
    localparam logic [HDR_POS_BITS-1:0] POS_SIG1      = 6'd1;
    localparam logic [HDR_POS_BITS-1:0] POS_OFFSET_LO = 6'd10;
    localparam logic [HDR_POS_BITS-1:0] POS_OFFSET_HI = 6'd13;
    localparam logic [HDR_POS_BITS-1:0] POS_INFO_LO   = 6'd14;
    localparam logic [HDR_POS_BITS-1:0] POS_INFO_HI   = 6'd17;
    localparam logic [HDR_POS_BITS-1:0] POS_WIDTH_LO  = 6'd18;
    localparam logic [HDR_POS_BITS-1:0] POS_WIDTH_HI  = 6'd21;
    localparam logic [HDR_POS_BITS-1:0] POS_HEIGHT_LO = 6'd22;
    localparam logic [HDR_POS_BITS-1:0] POS_HEIGHT_HI = 6'd25;
    localparam logic [HDR_POS_BITS-1:0] POS_DEPTH_LO  = 6'd28;
    localparam logic [HDR_POS_BITS-1:0] POS_DEPTH_HI  = 6'd29;
    localparam logic [HDR_POS_BITS-1:0] POS_COMP_LO   = 6'd30;
    localparam logic [HDR_POS_BITS-1:0] POS_COMP_HI   = 6'd33;
    localparam logic [HDR_POS_BITS-1:0] POS_TOTAL_LO  = 6'd34;
    localparam logic [HDR_POS_BITS-1:0] POS_TOTAL_HI  = 6'd37;

    // status codes
    localparam logic [3:0] ST_HEADER       = 4'd0;
    localparam logic [3:0] ST_PIXEL        = 4'd1;
    localparam logic [3:0] ST_PAD          = 4'd2;
    localparam logic [3:0] ST_DONE         = 4'd3;
    localparam logic [3:0] ERR_NONE        = 4'd0;
    localparam logic [3:0] ERR_SIGNATURE   = 4'd4;
    localparam logic [3:0] ERR_INFO_LEN    = 4'd5;
    localparam logic [3:0] ERR_COMPRESSION = 4'd6;
    localparam logic [3:0] ERR_DEPTH       = 4'd7;
    localparam logic [3:0] ERR_TOO_LARGE   = 4'd8;
    localparam logic [3:0] ERR_OFFSET      = 4'd9;
    localparam logic [3:0] ERR_TRUNCATED   = 4'd10;

    // one input word
    typedef struct packed {
        logic [7:0] file_byte;
        logic       start_of_file;
        logic       last_byte;
    } item_t;

    // header byte write from core to header unit
    typedef struct packed {
        logic                    en;
        logic [HDR_POS_BITS-1:0] pos;
        logic [7:0]              data;
    } hdr_wr_t;

    // header fields and derived values seen by the core
    typedef struct packed {
        logic [31:0]            pixel_offset;
        logic [31:0]            image_width;
        logic [31:0]            image_height;
        logic [31:0]            pixel_bytes_total;
        logic [USEFUL_BITS-1:0] row_useful;
        logic [USEFUL_BITS-1:0] row_total;
        logic [3:0]             check_code;
    } hdr_info_t;

    // one result word
    typedef struct packed {
        logic                     write_valid;
        logic [ADDR_OUT_BITS-1:0] write_address;
        logic [7:0]               write_data;
        logic [3:0]               status;
    } result_t;

endpackage

// ===== rtl/b24fb_in_reg.sv =====
// ----------------------------------------------------------------------------
// b24fb_in_reg
// Input register: holds one file byte word until the core takes it.
// ----------------------------------------------------------------------------
module b24fb_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  b24fb_pkg::item_t  in_item,
    input  logic              step,
    output logic              item_valid,
    output b24fb_pkg::item_t  item
);
    import b24fb_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    logic  accept;

    // free when empty or emptied this cycle
    assign in_ready = !valid_reg || step;
    assign accept   = in_valid && in_ready;

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (step)
        begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/b24fb_hdr.sv =====
// ----------------------------------------------------------------------------
// b24fb_hdr
// Header field capture, header checks and values derived from the image
// size (row lengths, size check product, address of the bottom image row).
// ----------------------------------------------------------------------------
module b24fb_hdr #(
    parameter int ADDRESS_BITS = b24fb_pkg::DEFAULT_ADDRESS_BITS
) (
    input  logic                             clk,
    input  b24fb_pkg::hdr_wr_t               hdr_wr,
    input  logic [b24fb_pkg::CAP_BITS-1:0]   capacity,
    output b24fb_pkg::hdr_info_t             info,
    output logic [ADDRESS_BITS-1:0]          base_init
);
    import b24fb_pkg::*;

    logic [7:0]      sig0_reg;
    logic [7:0]      sig1_reg;
    logic [3:0][7:0] offset_reg;
    logic [3:0][7:0] info_len_reg;
    logic [3:0][7:0] width_reg;
    logic [3:0][7:0] height_reg;
    logic [1:0][7:0] depth_reg;
    logic [3:0][7:0] comp_reg;
    logic [3:0][7:0] total_reg;
    logic [1:0]      lane;

    logic [31:0] width_w;
    logic [31:0] height_w;
    logic [20:0] width_clamp;
    logic [21:0] height_clamp;
    logic [42:0] size_prod;
    logic [42:0] size_prod_reg;
    logic        size_nz_reg;
    logic [44:0] size_bytes;
    logic        too_large_reg;

    logic [USEFUL_BITS-1:0]              useful_reg;
    logic [USEFUL_BITS-1:0]              row_total_reg;
    logic [31:0]                         height_m1;
    logic [ADDRESS_BITS+USEFUL_BITS-1:0] useful_wide;
    logic [2*ADDRESS_BITS-1:0]           base_prod;
    logic [ADDRESS_BITS-1:0]             base_init_reg;
    logic [3:0]                          check_code;

    // byte lane within a 32-bit field; all such fields start at 2 mod 4
    assign lane = hdr_wr.pos[1:0] - 2'd2;

    // little-endian field capture
    always_ff @(posedge clk)
    begin
        if (hdr_wr.en)
        begin
            case (hdr_wr.pos) inside
                POS_SIG0:                       sig0_reg <= hdr_wr.data;
                POS_SIG1:                       sig1_reg <= hdr_wr.data;
                [POS_OFFSET_LO:POS_OFFSET_HI]:  offset_reg[lane] <= hdr_wr.data;
                [POS_INFO_LO:POS_INFO_HI]:      info_len_reg[lane] <= hdr_wr.data;
                [POS_WIDTH_LO:POS_WIDTH_HI]:    width_reg[lane] <= hdr_wr.data;
                [POS_HEIGHT_LO:POS_HEIGHT_HI]:  height_reg[lane] <= hdr_wr.data;
                [POS_DEPTH_LO:POS_DEPTH_HI]:    depth_reg[hdr_wr.pos[0]] <= hdr_wr.data;
                [POS_COMP_LO:POS_COMP_HI]:      comp_reg[lane] <= hdr_wr.data;
                [POS_TOTAL_LO:POS_TOTAL_HI]:    total_reg[lane] <= hdr_wr.data;
                default:                        ;
            endcase
        end
    end

    assign width_w  = width_reg;
    assign height_w = height_reg;

    // size check: clamp so the product fits, any clamped side already exceeds
    // the largest capacity
    assign width_clamp  = (|width_w[31:20]) ? 21'h100000 : {1'b0, width_w[19:0]};
    assign height_clamp = (|height_w[31:21]) ? 22'h200000 : {1'b0, height_w[20:0]};
    assign size_prod    = width_clamp * height_clamp;
    assign size_bytes   = {1'b0, size_prod_reg, 1'b0} + {2'b00, size_prod_reg};

    // row length, padded row length and bottom image row address
    assign height_m1   = height_w - 32'd1;
    assign useful_wide = {{ADDRESS_BITS{1'b0}}, useful_reg};
    assign base_prod   = height_m1[ADDRESS_BITS-1:0] * useful_wide[ADDRESS_BITS-1:0];

    // derived values, settle long before the check byte
    always_ff @(posedge clk)
    begin
        size_prod_reg <= size_prod;
        size_nz_reg   <= (|width_w) && (|height_w);
        too_large_reg <= size_nz_reg && (size_bytes > {24'd0, capacity});
        useful_reg    <= {width_w[22:0], 1'b0} + {2'b00, width_w[21:0]};
        row_total_reg <= (useful_reg + 24'd3) & ~24'd3;
        base_init_reg <= base_prod[ADDRESS_BITS-1:0];
    end

    // header checks in priority order
    always_comb
    begin
        if (sig0_reg != SIG_B || sig1_reg != SIG_M)
        begin
            check_code = ERR_SIGNATURE;
        end
        else if (info_len_reg < MIN_INFO_LEN)
        begin
            check_code = ERR_INFO_LEN;
        end
        else if (comp_reg != 32'd0)
        begin
            check_code = ERR_COMPRESSION;
        end
        else if (depth_reg != DEPTH_24)
        begin
            check_code = ERR_DEPTH;
        end
        else if (too_large_reg)
        begin
            check_code = ERR_TOO_LARGE;
        end
        else if (offset_reg < HDR_BYTES)
        begin
            check_code = ERR_OFFSET;
        end
        else
        begin
            check_code = ERR_NONE;
        end
    end

    assign info.pixel_offset      = offset_reg;
    assign info.image_width       = width_w;
    assign info.image_height      = height_w;
    assign info.pixel_bytes_total = total_reg;
    assign info.row_useful        = useful_reg;
    assign info.row_total         = row_total_reg;
    assign info.check_code        = check_code;
    assign base_init              = base_init_reg;

endmodule

// ===== rtl/b24fb_core.sv =====
// ----------------------------------------------------------------------------
// b24fb_core
// Per-byte parser: file position, sticky error, pixel walk with row
// padding and bottom-up to top-down address generation.
// ----------------------------------------------------------------------------
module b24fb_core #(
    parameter int ADDRESS_BITS = b24fb_pkg::DEFAULT_ADDRESS_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  b24fb_pkg::item_t          item,
    input  b24fb_pkg::hdr_info_t      info,
    input  logic [ADDRESS_BITS-1:0]   base_init,
    output b24fb_pkg::hdr_wr_t        hdr_wr,
    output b24fb_pkg::result_t        result
);
    import b24fb_pkg::*;

    logic [31:0]             pos_reg;
    logic [3:0]              err_reg;
    logic [31:0]             seen_reg;
    logic [ROW_BITS-1:0]     rowpos_reg;
    logic [ROW_BITS-1:0]     row_reg;
    logic [ADDRESS_BITS-1:0] base_reg;

    logic [31:0]             pos_next;
    logic [3:0]              err_next;
    logic [31:0]             seen_next;
    logic [ROW_BITS-1:0]     rowpos_next;
    logic [ROW_BITS-1:0]     row_next;
    logic [ADDRESS_BITS-1:0] base_next;

    // state as seen by this byte, after a start of file
    logic [31:0]         pos_c;
    logic [3:0]          err_c;
    logic [31:0]         seen_c;
    logic [ROW_BITS-1:0] rowpos_c;
    logic [ROW_BITS-1:0] row_c;

    logic                                  in_header;
    logic                                  empty_image;
    logic                                  fin_before;
    logic                                  fin_after;
    logic [ROW_BITS-1:0]                   rowpos_inc;
    logic                                  row_end;
    logic [ADDRESS_BITS+ROW_BITS-1:0]      rowpos_wide;
    logic [ADDRESS_BITS+USEFUL_BITS-1:0]   useful_wide;
    logic [ADDRESS_BITS-1:0]               useful_ab;
    logic [ADDRESS_BITS-1:0]               addr_ab;
    logic [ADDRESS_BITS+ADDR_OUT_BITS-1:0] addr_wide;
    result_t                               res;

    assign pos_c    = item.start_of_file ? 32'd0 : pos_reg;
    assign err_c    = item.start_of_file ? ERR_NONE : err_reg;
    assign seen_c   = item.start_of_file ? 32'd0 : seen_reg;
    assign rowpos_c = item.start_of_file ? '0 : rowpos_reg;
    assign row_c    = item.start_of_file ? '0 : row_reg;

    assign in_header = pos_c < HDR_BYTES;

    // header bytes go to the header unit
    assign hdr_wr.en   = step && in_header && (err_c == ERR_NONE);
    assign hdr_wr.pos  = pos_c[HDR_POS_BITS-1:0];
    assign hdr_wr.data = item.file_byte;

    // pixel array bookkeeping
    assign empty_image = (info.image_width == 32'd0) || (info.image_height == 32'd0) ||
                         (info.pixel_bytes_total == 32'd0);
    assign fin_before  = empty_image || (seen_c >= info.pixel_bytes_total) ||
                         ({10'd0, row_c} >= info.image_height);
    assign rowpos_inc  = rowpos_c + 1'b1;
    assign row_end     = {2'b00, rowpos_inc} >= info.row_total;

    // address = top-down row base + byte within row, modulo the address space
    assign rowpos_wide = {{ADDRESS_BITS{1'b0}}, rowpos_c};
    assign useful_wide = {{ADDRESS_BITS{1'b0}}, info.row_useful};
    assign useful_ab   = useful_wide[ADDRESS_BITS-1:0];
    assign addr_ab     = base_reg + rowpos_wide[ADDRESS_BITS-1:0];
    assign addr_wide   = {{ADDR_OUT_BITS{1'b0}}, addr_ab};

    // per-byte decision
    always_comb
    begin
        pos_next    = (pos_c == 32'hFFFF_FFFF) ? pos_c : pos_c + 32'd1;
        err_next    = err_c;
        seen_next   = seen_c;
        rowpos_next = rowpos_c;
        row_next    = row_c;
        base_next   = base_reg;
        fin_after   = 1'b1;
        res         = '0;

        if (err_c != ERR_NONE)
        begin
            res.status = err_c;
        end
        else
        begin
            if (in_header)
            begin
                if (pos_c == HDR_CHECK_POS)
                begin
                    err_next  = info.check_code;
                    base_next = base_init;
                end
                res.status = err_next;
            end
            else if (pos_c < info.pixel_offset)
            begin
                res.status = ST_HEADER;
            end
            else if (fin_before)
            begin
                res.status = ST_DONE;
            end
            else
            begin
                if ({2'b00, rowpos_c} < info.row_useful)
                begin
                    res.write_valid   = 1'b1;
                    res.write_address = addr_wide[ADDR_OUT_BITS-1:0];
                    res.write_data    = item.file_byte;
                    res.status        = ST_PIXEL;
                end
                else
                begin
                    res.status = ST_PAD;
                end
                seen_next = seen_c + 32'd1;
                if (row_end)
                begin
                    rowpos_next = '0;
                    row_next    = row_c + 1'b1;
                    base_next   = base_reg - useful_ab;
                end
                else
                begin
                    rowpos_next = rowpos_inc;
                end
            end

            // file ended early
            fin_after = empty_image || (seen_next >= info.pixel_bytes_total) ||
                        ({10'd0, row_next} >= info.image_height);
            if (item.last_byte && (err_next == ERR_NONE) &&
                ((pos_c < HDR_CHECK_POS) || !fin_after))
            begin
                err_next   = ERR_TRUNCATED;
                res.status = ERR_TRUNCATED;
            end
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            err_reg    <= ERR_NONE;
            seen_reg   <= '0;
            rowpos_reg <= '0;
            row_reg    <= '0;
        end
        else if (step)
        begin
            pos_reg    <= pos_next;
            err_reg    <= err_next;
            seen_reg   <= seen_next;
            rowpos_reg <= rowpos_next;
            row_reg    <= row_next;
        end
    end

    // row base address, loaded at the check byte, moved back one row at each row end
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            base_reg <= base_next;
        end
    end

    assign result = res;

endmodule

// ===== rtl/b24fb_out_reg.sv =====
// ----------------------------------------------------------------------------
// b24fb_out_reg
// Result register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module b24fb_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  b24fb_pkg::result_t  res_in,
    output logic                space,
    output logic                out_valid,
    input  logic                out_ready,
    output b24fb_pkg::result_t  res_out
);
    import b24fb_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    // room for a new word when empty or drained this cycle
    assign space = !valid_reg || out_ready;

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (step)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

// ===== rtl/bmp24_stream_to_framebuffer.sv =====
// ----------------------------------------------------------------------------
// bmp24_stream_to_framebuffer
// Streaming decoder for uncompressed 24-bit BMP files: one file byte in,
// one result word out, with frame buffer address for pixel bytes.
// ----------------------------------------------------------------------------
// path: an accepted byte waits in the input register, and the parser logic
//   loads its result into the result register when that register has room
// throughput: 1 byte per cycle sustained; stalls only while the result
//   register is full and not taken
// reset: control state cleared, buffer capacity set to 1048576; no clear pass
// ----------------------------------------------------------------------------
module bmp24_stream_to_framebuffer #(
    parameter int ADDRESS_BITS = b24fb_pkg::DEFAULT_ADDRESS_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_enable,
    input  logic [b24fb_pkg::CAP_BITS-1:0]       cfg_write_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [7:0]                           file_byte,
    input  logic                                 start_of_file,
    input  logic                                 last_byte,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 write_valid,
    output logic [b24fb_pkg::ADDR_OUT_BITS-1:0]  write_address,
    output logic [7:0]                           write_data,
    output logic [3:0]                           status
);
    import b24fb_pkg::*;

    logic [CAP_BITS-1:0]     capacity_reg;
    item_t                   in_item;
    item_t                   item;
    logic                    item_valid;
    logic                    out_space;
    logic                    step;
    hdr_wr_t                 hdr_wr;
    hdr_info_t               info;
    logic [ADDRESS_BITS-1:0] base_init;
    result_t                 res_core;
    result_t                 res_out;

    // buffer capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_write_enable)
        begin
            capacity_reg <= cfg_write_data;
        end
    end

    assign in_item.file_byte     = file_byte;
    assign in_item.start_of_file = start_of_file;
    assign in_item.last_byte     = last_byte;

    // core advances when a byte is held and the result register has room
    assign step = item_valid && out_space;

    b24fb_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .step       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    b24fb_hdr #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_hdr (
        .clk       (clk),
        .hdr_wr    (hdr_wr),
        .capacity  (capacity_reg),
        .info      (info),
        .base_init (base_init)
    );

    b24fb_core #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (item),
        .info      (info),
        .base_init (base_init),
        .hdr_wr    (hdr_wr),
        .result    (res_core)
    );

    b24fb_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .res_in    (res_core),
        .space     (out_space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_out   (res_out)
    );

    assign write_valid   = res_out.write_valid;
    assign write_address = res_out.write_address;
    assign write_data    = res_out.write_data;
    assign status        = res_out.status;

endmodule

// ===== rtl/b24fb_checker.sv =====
// ----------------------------------------------------------------------------
// b24fb_checker
// Port-level checks for the BMP stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module b24fb_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic                                 write_valid,
    input  logic [b24fb_pkg::ADDR_OUT_BITS-1:0]  write_address,
    input  logic [7:0]                           write_data,
    input  logic [3:0]                           status
);
    import b24fb_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(write_valid) &&
        $stable(write_address) && $stable(write_data) && $stable(status))
        else $error("result word changed while stalled");

    // upstream only stalls behind a stalled result
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled while output side free");

    // a frame buffer write is a pixel byte, flagged truncated when the file
    // ends on it
    a_write_is_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (write_valid ? ((status == ST_PIXEL) || (status == ERR_TRUNCATED))
                                   : (status != ST_PIXEL)))
        else $error("write flag disagrees with status");

    // no write means zero address and data
    a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_valid |-> (write_address == '0) && (write_data == 8'd0))
        else $error("nonzero write fields without a write");

endmodule

bind bmp24_stream_to_framebuffer b24fb_checker u_b24fb_checker (.*);
